[design/bclm_pkg.sv]
// Shared types, constants and register codes for the B-curve loudness meter.
package bclm_pkg;

  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_LEAK_RATE   = 2'd0;
  localparam logic [1:0] REG_HP_GAIN     = 2'd1;
  localparam logic [1:0] REG_HP_FEEDBACK = 2'd2;

  localparam logic [31:0] LEAK_RATE_RST   = 32'd2781721;
  localparam logic [15:0] HP_GAIN_RST     = 16'd32308;
  localparam logic [15:0] HP_FEEDBACK_RST = 16'd31847;

  localparam int Y_W        = 24;
  localparam int MS_W       = 48;
  localparam int MANT_W     = 31;
  localparam int FRAC_W     = 20;
  localparam int NORM_STEPS = 6;
  localparam int LOG_ITERS  = 20;
  localparam int CNT_W      = 5;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int P_W        = 56;
  localparam int DB_W       = 16;

  localparam logic [25:0] DB_SCALE = 26'd50504453;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_FF,
    OP_FB,
    OP_Y,
    OP_SQ,
    OP_DIFF,
    OP_LHI,
    OP_LLO,
    OP_ACC,
    OP_NINIT,
    OP_NORM,
    OP_MINIT,
    OP_LOG,
    OP_DB,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] norm_step;
  } dp_cmd_t;

  typedef struct packed {
    logic ms_zero;
  } dp_stat_t;

endpackage

[design/bclm_ctrl.sv]
// Sequencer for the loudness meter: steps the datapath through filter, power and log phases.
module bclm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last_of_frame,
  output logic               in_stall,
  input  logic               out_stall,
  output logic               out_valid,
  output bclm_pkg::dp_cmd_t  cmd,
  input  bclm_pkg::dp_stat_t stat
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_FB    = 14'b00000000000010,
    S_Y     = 14'b00000000000100,
    S_SQ    = 14'b00000000001000,
    S_DIFF  = 14'b00000000010000,
    S_LHI   = 14'b00000000100000,
    S_LLO   = 14'b00000001000000,
    S_ACC   = 14'b00000010000000,
    S_NINIT = 14'b00000100000000,
    S_NORM  = 14'b00001000000000,
    S_MINIT = 14'b00010000000000,
    S_LOG   = 14'b00100000000000,
    S_DB    = 14'b01000000000000,
    S_EMIT  = 14'b10000000000000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [bclm_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       last_r, last_nxt;
  logic                       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd.op        = bclm_pkg::OP_NONE;
    cmd.norm_step = cnt_r[2:0];
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = bclm_pkg::OP_FF;
          last_nxt  = in_last_of_frame;
          state_nxt = S_FB;
        end
      end
      S_FB: begin
        cmd.op    = bclm_pkg::OP_FB;
        state_nxt = S_Y;
      end
      S_Y: begin
        cmd.op    = bclm_pkg::OP_Y;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.op    = bclm_pkg::OP_SQ;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.op    = bclm_pkg::OP_DIFF;
        state_nxt = S_LHI;
      end
      S_LHI: begin
        cmd.op    = bclm_pkg::OP_LHI;
        state_nxt = S_LLO;
      end
      S_LLO: begin
        cmd.op    = bclm_pkg::OP_LLO;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op    = bclm_pkg::OP_ACC;
        state_nxt = last_r ? S_NINIT : S_IDLE;
      end
      S_NINIT: begin
        cmd.op  = bclm_pkg::OP_NINIT;
        cnt_nxt = '0;
        if (stat.ms_zero) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        cmd.op = bclm_pkg::OP_NORM;
        if (cnt_r == bclm_pkg::CNT_W'(bclm_pkg::NORM_STEPS - 1)) begin
          state_nxt = S_MINIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_MINIT: begin
        cmd.op    = bclm_pkg::OP_MINIT;
        cnt_nxt   = '0;
        state_nxt = S_LOG;
      end
      S_LOG: begin
        cmd.op = bclm_pkg::OP_LOG;
        if (cnt_r == bclm_pkg::CNT_W'(bclm_pkg::LOG_ITERS - 1)) begin
          state_nxt = S_DB;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DB: begin
        cmd.op    = bclm_pkg::OP_DB;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op        = bclm_pkg::OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[design/bclm_dpath.sv]
// Datapath for the loudness meter: high-pass filter, leaky mean square and dB conversion.
module bclm_dpath #(
  parameter int SAMPLE_BITS = bclm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bclm_pkg::dp_cmd_t                cmd,
  output bclm_pkg::dp_stat_t               stat,
  input  logic signed [SAMPLE_BITS-1:0]    in_sample,
  input  logic [31:0]                      leak_rate,
  input  logic [15:0]                      hp_gain,
  input  logic [15:0]                      hp_feedback,
  output logic signed [bclm_pkg::DB_W-1:0] loudness_db
);

  localparam int D_W      = SAMPLE_BITS + 1;
  localparam int FF_SHIFT = 31 - SAMPLE_BITS;
  localparam int ACC_W    = 50;
  localparam int YQ_W     = ACC_W - 23;
  localparam int MS_W     = bclm_pkg::MS_W;
  localparam int MUL_W    = bclm_pkg::MUL_W;
  localparam int P_W      = bclm_pkg::P_W;
  localparam int LEAK_W   = MS_W + 32;
  localparam int L2_W     = 7 + bclm_pkg::FRAC_W;
  localparam int DBF_W    = P_W + 1 - 36;

  logic signed [SAMPLE_BITS-1:0]      x_r;
  logic signed [SAMPLE_BITS-1:0]      prev_in_r;
  logic signed [bclm_pkg::Y_W-1:0]    prev_y_r;
  logic [MS_W-1:0]                    ms_r;
  logic signed [P_W-1:0]              p_r;
  logic signed [ACC_W-1:0]            ff_r;
  logic [P_W-1:0]                     hi_r;
  logic [MS_W-1:0]                    diff_r;
  logic                               ge_r;
  logic [MS_W-1:0]                    norm_r;
  logic [5:0]                         n_r;
  logic                               zero_r;
  logic [bclm_pkg::MANT_W-1:0]        m_r;
  logic [bclm_pkg::FRAC_W-1:0]        frac_r;
  logic signed [bclm_pkg::DB_W-1:0]   db_r;

  logic signed [D_W-1:0]              d_in;
  logic signed [MUL_W-1:0]            mul_a, mul_b;
  logic signed [bclm_pkg::PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]            acc;
  logic signed [YQ_W-1:0]             yq;
  logic signed [bclm_pkg::Y_W-1:0]    ysat;
  logic [MS_W-1:0]                    y2;
  logic [LEAK_W-1:0]                  leak_sum;
  logic [MS_W-1:0]                    step;
  logic [31:0]                        sq;
  logic signed [6:0]                  n_off;
  logic signed [L2_W-1:0]             l2;
  logic signed [P_W:0]                db_sum;
  logic signed [DBF_W-1:0]            db_full;
  logic signed [bclm_pkg::DB_W-1:0]   db_sat;
  logic [MS_W+5:0]                    norm_out;

  function automatic logic [MS_W+5:0] norm_shift(input logic [MS_W-1:0] v,
                                                 input logic [5:0] n,
                                                 input logic [2:0] k);
    logic [MS_W-1:0] vo;
    logic [5:0]      no;
    vo = v;
    no = n;
    case (k)
      3'd0: if (v[47:16] == '0) begin vo = v << 32; no = n - 6'd32; end
      3'd1: if (v[47:32] == '0) begin vo = v << 16; no = n - 6'd16; end
      3'd2: if (v[47:40] == '0) begin vo = v << 8;  no = n - 6'd8;  end
      3'd3: if (v[47:44] == '0) begin vo = v << 4;  no = n - 6'd4;  end
      3'd4: if (v[47:46] == '0) begin vo = v << 2;  no = n - 6'd2;  end
      3'd5: if (!v[47]) begin vo = v << 1; no = n - 6'd1; end
      default: begin
        vo = v;
        no = n;
      end
    endcase
    return {vo, no};
  endfunction

  assign d_in  = D_W'(in_sample) - D_W'(prev_in_r);
  assign n_off = $signed({1'b0, n_r}) - 7'sd44;
  assign l2    = $signed({n_off, frac_r});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      bclm_pkg::OP_FF: begin
        mul_a = MUL_W'(d_in);
        mul_b = $signed({17'b0, hp_gain});
      end
      bclm_pkg::OP_FB: begin
        mul_a = MUL_W'(prev_y_r);
        mul_b = $signed({17'b0, hp_feedback});
      end
      bclm_pkg::OP_SQ: begin
        mul_a = MUL_W'(prev_y_r);
        mul_b = MUL_W'(prev_y_r);
      end
      bclm_pkg::OP_LHI: begin
        mul_a = $signed({9'b0, diff_r[47:24]});
        mul_b = $signed({1'b0, leak_rate});
      end
      bclm_pkg::OP_LLO: begin
        mul_a = $signed({9'b0, diff_r[23:0]});
        mul_b = $signed({1'b0, leak_rate});
      end
      bclm_pkg::OP_LOG: begin
        mul_a = $signed({2'b0, m_r});
        mul_b = $signed({2'b0, m_r});
      end
      bclm_pkg::OP_DB: begin
        mul_a = MUL_W'(l2);
        mul_b = $signed({7'b0, bclm_pkg::DB_SCALE});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    acc = ff_r + (ACC_W'(p_r) <<< 8) + ACC_W'(64'sd4194304);
    yq  = YQ_W'(acc >>> 23);
    if (yq > YQ_W'(64'sd8388607)) begin
      ysat = 24'sh7FFFFF;
    end else if (yq < -YQ_W'(64'sd8388608)) begin
      ysat = -24'sh800000;
    end else begin
      ysat = bclm_pkg::Y_W'(yq);
    end
  end

  assign y2       = p_r[MS_W-1:0];
  assign leak_sum = {hi_r, 24'b0} + LEAK_W'(p_r[P_W-1:0]) + LEAK_W'(64'h8000_0000);
  assign step     = leak_sum[LEAK_W-1:32];
  assign sq       = prod[61:30];
  assign norm_out = norm_shift(norm_r, n_r, cmd.norm_step);

  always_comb begin
    db_sum  = (P_W+1)'(p_r) + (P_W+1)'(64'sd34359738368);
    db_full = DBF_W'(db_sum >>> 36);
    if (zero_r || db_full < -DBF_W'(64'sd32768)) begin
      db_sat = -16'sh8000;
    end else if (db_full > DBF_W'(64'sd32767)) begin
      db_sat = 16'sh7FFF;
    end else begin
      db_sat = bclm_pkg::DB_W'(db_full);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_in_r <= '0;
      prev_y_r  <= '0;
      ms_r      <= '0;
    end else begin
      case (cmd.op)
        bclm_pkg::OP_Y: begin
          prev_in_r <= x_r;
          prev_y_r  <= ysat;
        end
        bclm_pkg::OP_ACC: begin
          ms_r <= ge_r ? ms_r + step : ms_r - step;
        end
        default: begin
          ms_r <= ms_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      bclm_pkg::OP_FF: begin
        x_r <= in_sample;
        p_r <= prod[P_W-1:0];
      end
      bclm_pkg::OP_FB: begin
        ff_r <= ACC_W'(p_r) <<< FF_SHIFT;
        p_r  <= prod[P_W-1:0];
      end
      bclm_pkg::OP_SQ: begin
        p_r <= prod[P_W-1:0];
      end
      bclm_pkg::OP_DIFF: begin
        ge_r   <= (y2 >= ms_r);
        diff_r <= (y2 >= ms_r) ? y2 - ms_r : ms_r - y2;
      end
      bclm_pkg::OP_LHI: begin
        p_r <= prod[P_W-1:0];
      end
      bclm_pkg::OP_LLO: begin
        hi_r <= p_r;
        p_r  <= prod[P_W-1:0];
      end
      bclm_pkg::OP_NINIT: begin
        norm_r <= ms_r;
        n_r    <= 6'd47;
        zero_r <= (ms_r == '0);
      end
      bclm_pkg::OP_NORM: begin
        norm_r <= norm_out[MS_W+5:6];
        n_r    <= norm_out[5:0];
      end
      bclm_pkg::OP_MINIT: begin
        m_r    <= norm_r[47:17];
        frac_r <= '0;
      end
      bclm_pkg::OP_LOG: begin
        if (sq[31]) begin
          m_r    <= sq[31:1];
          frac_r <= {frac_r[bclm_pkg::FRAC_W-2:0], 1'b1};
        end else begin
          m_r    <= sq[30:0];
          frac_r <= {frac_r[bclm_pkg::FRAC_W-2:0], 1'b0};
        end
      end
      bclm_pkg::OP_DB: begin
        p_r <= prod[P_W-1:0];
      end
      bclm_pkg::OP_EMIT: begin
        db_r <= db_sat;
      end
      default: begin
        p_r <= p_r;
      end
    endcase
  end

  assign stat.ms_zero = (ms_r == '0);
  assign loudness_db  = db_r;

endmodule

[design/bcurve_loudness_meter.sv]
// Top level of the B-curve loudness meter: register file, sequencer and datapath.
// A sample without end-of-frame flag runs the filter and leak steps on the shared multiplier,
// while in_stall holds off the next sample. An end-of-frame sample adds the 6-step normalise
// search and 20 squaring passes of the logarithm, both skipped when the mean square is zero.
// The next sample is taken while a result still waits on out_stall.
// Synchronous active-low reset clears filter state, mean square and registers to defaults.
module bcurve_loudness_meter #(
  parameter int SAMPLE_BITS = bclm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [SAMPLE_BITS-1:0]          in_sample,
  input  logic                                   in_last_of_frame,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [bclm_pkg::DB_W-1:0]       out_loudness_db,
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [bclm_pkg::CFG_ADDR_W-1:0]        cfg_paddr,
  input  logic [bclm_pkg::CFG_DATA_W-1:0]        cfg_pwdata,
  output logic [bclm_pkg::CFG_DATA_W-1:0]        cfg_prdata,
  output logic                                   cfg_pready
);

  logic [31:0]        leak_rate_r;
  logic [15:0]        hp_gain_r;
  logic [15:0]        hp_feedback_r;
  logic               cfg_wr;
  bclm_pkg::dp_cmd_t  cmd;
  bclm_pkg::dp_stat_t stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leak_rate_r   <= bclm_pkg::LEAK_RATE_RST;
      hp_gain_r     <= bclm_pkg::HP_GAIN_RST;
      hp_feedback_r <= bclm_pkg::HP_FEEDBACK_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        bclm_pkg::REG_LEAK_RATE:   leak_rate_r   <= cfg_pwdata;
        bclm_pkg::REG_HP_GAIN:     hp_gain_r     <= cfg_pwdata[15:0];
        bclm_pkg::REG_HP_FEEDBACK: hp_feedback_r <= cfg_pwdata[15:0];
        default: begin
          leak_rate_r <= leak_rate_r;
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      bclm_pkg::REG_LEAK_RATE:   cfg_prdata = leak_rate_r;
      bclm_pkg::REG_HP_GAIN:     cfg_prdata = {16'b0, hp_gain_r};
      bclm_pkg::REG_HP_FEEDBACK: cfg_prdata = {16'b0, hp_feedback_r};
      default:                   cfg_prdata = '0;
    endcase
  end

  bclm_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_last_of_frame (in_last_of_frame),
    .in_stall         (in_stall),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .cmd              (cmd),
    .stat             (stat)
  );

  bclm_dpath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_sample   (in_sample),
    .leak_rate   (leak_rate_r),
    .hp_gain     (hp_gain_r),
    .hp_feedback (hp_feedback_r),
    .loudness_db (out_loudness_db)
  );

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("sequencer did not leave idle after an input transfer");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a sample in progress");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

endmodule
